### sv/qfg_pkg.sv
// qfg_pkg: constants shared by the quadratic fade-out gain block
// csr widths, indexes and reset values, datapath widths, the 1/1000 reciprocal
// no dependencies
package qfg_pkg;

   // csr field widths
   localparam int RATE_W     = 18;
   localparam int MS_W       = 14;
   localparam int CH_W       = 4;
   localparam int SEG_LEN_W  = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_MS        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENT_LENGTH = 2'd3;

   // csr reset values
   localparam logic [RATE_W-1:0]    RATE_RESET = 18'd44100;
   localparam logic [MS_W-1:0]      MS_RESET   = 14'd0;
   localparam logic [CH_W-1:0]      CH_RESET   = 4'd2;
   localparam logic [SEG_LEN_W-1:0] SEG_RESET  = 24'd0;

   // datapath widths
   localparam int MUL_W   = 32;        // multiplier operand width
   localparam int PROD_W  = 2 * MUL_W;
   localparam int LEN_W   = 23;        // fade length in frames, below 2^32 / 1000
   localparam int SPAN_W  = LEN_W + CH_W;
   localparam int L2_W    = 2 * LEN_W; // square of the fade length
   localparam int REM_W   = L2_W + 1;  // divider remainder, below twice the divisor
   localparam int GROUP_W = 22;
   localparam int KSQ_W   = 2 * GROUP_W;
   localparam int FRAC_W  = 16;        // gain is Q1.16
   localparam int GAIN_W  = FRAC_W + 1;
   localparam int DCNT_W  = 5;

   // floor(x / 1000) = (x * RECIP_1000) >> RECIP_SHIFT for any 32-bit x
   localparam logic [MUL_W-1:0] RECIP_1000  = 32'h1062_4DD3;
   localparam int               RECIP_SHIFT = 38;

   // last quotient bit index of the gain division
   localparam logic [DCNT_W-1:0] DIV_LAST = 5'(GAIN_W - 1);

endpackage

### sv/quadratic_fadeout_gain.sv
// quadratic_fadeout_gain: quadratic fade-out envelope over the tail of a segment
// one shared multiplier and one shift-subtract divider under a small sequencer
// depends on qfg_pkg
//
// usage
//   req channel carries one interleaved sample per word, tuser flags the first
//   sample of a new segment. rsp channel returns the faded sample, one word per
//   request word, in order. the user must write the csr registers sample_rate,
//   fade_ms, channel_count and segment_length only while idle; not enforced.
// sequencing
//   an accepted word passes the rate, recip, span and sqr states; outside the
//   fade it goes to done unchanged. in the fade ksq follows, then apply at once
//   for a zero gain, else divinit and the gain divider, one quotient bit a
//   cycle, before apply and round. req_tready is high only while the sequencer
//   is idle, so the next word is taken only after the previous one has left
//   the done state.
// reset
//   csr registers go to their defaults (44100, 0, 2, 0), sample counters clear,
//   no output word is pending.
// stall
//   a finished word waits in the output register; the next word is accepted
//   meanwhile and its result waits in the sequencer until the register frees.
module quadratic_fadeout_gain
   import qfg_pkg::*;
#(
   parameter int SEGMENT_BITS = 24,
   parameter int SAMPLE_BITS  = 24,
   parameter int MAX_CHANNELS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] req_tdata,  // sample_in
   input  logic                                   req_tuser,  // segment_start
   // result channel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] rsp_tdata,  // sample_out
   // csr write port
   input  logic                                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]                   csr_index,
   input  logic [CSR_DATA_W-1:0]                  csr_wdata
);

   localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int PH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CMP_W  = (SEGMENT_BITS > SEG_LEN_W) ? SEGMENT_BITS : SEG_LEN_W;

   // sequencer states
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_RATE    = 4'd1;
   localparam logic [3:0] ST_RECIP   = 4'd2;
   localparam logic [3:0] ST_SPAN    = 4'd3;
   localparam logic [3:0] ST_SQR     = 4'd4;
   localparam logic [3:0] ST_KSQ     = 4'd5;
   localparam logic [3:0] ST_DIVINIT = 4'd6;
   localparam logic [3:0] ST_DIV     = 4'd7;
   localparam logic [3:0] ST_APPLY   = 4'd8;
   localparam logic [3:0] ST_ROUND   = 4'd9;
   localparam logic [3:0] ST_DONE    = 4'd10;

   // csr registers
   logic [RATE_W-1:0]    rate_ff, rate_in;
   logic [MS_W-1:0]      ms_ff, ms_in;
   logic [CH_W-1:0]      chan_ff, chan_in;
   logic [SEG_LEN_W-1:0] seg_ff, seg_in;

   // sequencer and datapath registers
   logic [3:0]              state_ff, state_in;
   logic [SAMPLE_BITS-1:0]  sample_ff, sample_in;
   logic [SEGMENT_BITS-1:0] idx_ff, idx_in;
   logic [PH_W-1:0]         phase_ff, phase_in;
   logic [GROUP_W-1:0]      group_ff, group_in;
   logic [PROD_W-1:0]       mul_ff, mul_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [L2_W-1:0]         l2_ff, l2_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [GAIN_W-1:0]       quo_ff, quo_in;
   logic [DCNT_W-1:0]       div_cnt_ff, div_cnt_in;
   logic [SAMPLE_BITS-1:0]  res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]  rsp_data_ff, rsp_data_in;

   // combinational helpers
   logic [MUL_W-1:0]       mul_a, mul_b;
   logic [CH_W-1:0]        ch_used;
   logic [LEN_W-1:0]       len_div;
   logic [SPAN_W-1:0]      span;
   logic [SEG_LEN_W-1:0]   start_idx;
   logic                   in_fade;
   logic                   div_bit;
   logic [REM_W-1:0]       div_diff;
   logic                   neg;
   logic [SAMPLE_BITS-1:0] mag;
   logic [SAMPLE_BITS-1:0] prod;
   logic [PH_W:0]          ph_inc;
   logic                   out_free;

   // csr writes
   always_comb begin
      rate_in = rate_ff;
      ms_in   = ms_ff;
      chan_in = chan_ff;
      seg_in  = seg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SAMPLE_RATE:    rate_in = csr_wdata[RATE_W-1:0];
            CSR_FADE_MS:        ms_in   = csr_wdata[MS_W-1:0];
            CSR_CHANNEL_COUNT:  chan_in = csr_wdata[CH_W-1:0];
            CSR_SEGMENT_LENGTH: seg_in  = csr_wdata[SEG_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // channel count clamped to 1..MAX_CHANNELS
   always_comb begin
      if (chan_ff == '0) begin
         ch_used = CH_W'(1);
      end else if ({1'b0, chan_ff} > (CH_W + 1)'(MAX_CHANNELS)) begin
         ch_used = CH_W'(MAX_CHANNELS);
      end else begin
         ch_used = chan_ff;
      end
   end

   // fade length, fade start and the in-fade test
   assign len_div   = mul_ff[RECIP_SHIFT + LEN_W - 1:RECIP_SHIFT];
   assign span      = mul_ff[SPAN_W-1:0];
   assign start_idx = ({{(SPAN_W - SEG_LEN_W){1'b0}}, seg_ff} <= span) ? '0 :
                      seg_ff - span[SEG_LEN_W-1:0] - SEG_LEN_W'(1);
   assign in_fade   = (len_ff != '0) && (CMP_W'(idx_ff) >= CMP_W'(start_idx));

   // divider step: one quotient bit per cycle
   assign div_diff = rem_ff - {1'b0, l2_ff};
   assign div_bit  = (rem_ff >= {1'b0, l2_ff});

   // sign and magnitude of the sample
   assign neg  = sample_ff[SAMPLE_BITS-1];
   assign mag  = neg ? (~sample_ff + SAMPLE_BITS'(1)) : sample_ff;
   assign prod = mul_ff[SAMPLE_BITS + FRAC_W - 1:FRAC_W];

   assign ph_inc   = {1'b0, phase_ff} + (PH_W + 1)'(1);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_RATE: begin
            mul_a = MUL_W'(rate_ff);
            mul_b = MUL_W'(ms_ff);
         end
         ST_RECIP: begin
            mul_a = mul_ff[MUL_W-1:0];
            mul_b = RECIP_1000;
         end
         ST_SPAN: begin
            mul_a = MUL_W'(len_div);
            mul_b = MUL_W'(ch_used);
         end
         ST_SQR: begin
            mul_a = MUL_W'(len_ff);
            mul_b = MUL_W'(len_ff);
         end
         ST_KSQ: begin
            mul_a = MUL_W'(group_ff);
            mul_b = MUL_W'(group_ff);
         end
         ST_APPLY: begin
            mul_a = MUL_W'(mag);
            mul_b = MUL_W'(quo_ff);
         end
         default: ;
      endcase
   end

   assign mul_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      idx_in       = idx_ff;
      phase_in     = phase_ff;
      group_in     = group_ff;
      len_in       = len_ff;
      l2_in        = l2_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_cnt_in   = div_cnt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sample_in = req_tdata[SAMPLE_BITS-1:0];
               if (req_tuser) begin
                  idx_in   = '0;
                  phase_in = '0;
                  group_in = '0;
               end
               state_in = ST_RATE;
            end
         end
         ST_RATE:  state_in = ST_RECIP;
         ST_RECIP: state_in = ST_SPAN;
         ST_SPAN: begin
            len_in   = len_div;
            state_in = ST_SQR;
         end
         ST_SQR: begin
            // outside the fade the sample passes unchanged
            if (in_fade) begin
               state_in = ST_KSQ;
            end else begin
               res_in   = sample_ff;
               state_in = ST_DONE;
            end
         end
         ST_KSQ: begin
            l2_in = mul_ff[L2_W-1:0];
            if ((GROUP_W + 1)'(group_ff) >= (GROUP_W + 1)'(len_ff)) begin
               quo_in   = '0;
               state_in = ST_APPLY;
            end else begin
               state_in = ST_DIVINIT;
            end
         end
         ST_DIVINIT: begin
            rem_in     = {1'b0, l2_ff - L2_W'(mul_ff[KSQ_W-1:0])};
            quo_in     = '0;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            rem_in     = div_bit ? {div_diff[L2_W-1:0], 1'b0} : {rem_ff[L2_W-1:0], 1'b0};
            quo_in     = {quo_ff[GAIN_W-2:0], div_bit};
            div_cnt_in = div_cnt_ff + DCNT_W'(1);
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: state_in = ST_ROUND;
         ST_ROUND: begin
            res_in = neg ? (~prod + SAMPLE_BITS'(1)) : prod;
            // advance the fade group counters
            if (ph_inc >= (PH_W + 1)'(ch_used)) begin
               phase_in = '0;
               if (group_ff != '1) begin
                  group_in = group_ff + GROUP_W'(1);
               end
            end else begin
               phase_in = ph_inc[PH_W-1:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               if (idx_ff != '1) begin
                  idx_in = idx_ff + SEGMENT_BITS'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff      <= RATE_RESET;
         ms_ff        <= MS_RESET;
         chan_ff      <= CH_RESET;
         seg_ff       <= SEG_RESET;
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         phase_ff     <= '0;
         group_ff     <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rate_ff      <= rate_in;
         ms_ff        <= ms_in;
         chan_ff      <= chan_in;
         seg_ff       <= seg_in;
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         phase_ff     <= phase_in;
         group_ff     <= group_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      mul_ff      <= mul_in;
      len_ff      <= len_in;
      l2_ff       <= l2_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_data_ff);

   // a word in flight blocks the next one
   a_one_at_a_time : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a word was in flight");

   // gain never exceeds unity
   a_gain_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |-> (quo_ff <= GAIN_W'(1 << FRAC_W)))
      else $error("fade gain above unity");

   // divider count never passes its last quotient bit
   a_div_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_cnt_ff <= DIV_LAST))
      else $error("gain divider ran past its last bit");

   // group phase stays inside one frame
   a_phase_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && $past(state_ff == ST_ROUND)
         |-> ((PH_W + 1)'(phase_ff) < (PH_W + 1)'(ch_used)))
      else $error("group phase left the frame");

endmodule

### tb/qfg_checker.sv
`timescale 1ns / 100ps
// qfg_checker: scoreboard for the quadratic fade-out gain block
// watches the csr, req and rsp channels, predicts each faded word and compares
// depends on qfg_pkg
module qfg_checker
   import qfg_pkg::*;
#(
   parameter int SEGMENT_BITS = 24,
   parameter int SAMPLE_BITS  = 24,
   parameter int MAX_CHANNELS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   input  logic                                   req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] req_tdata,  // sample_in
   input  logic                                   req_tuser,  // segment_start
   input  logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] rsp_tdata,  // sample_out
   input  logic                                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]                   csr_index,
   input  logic [CSR_DATA_W-1:0]                  csr_wdata,
   output int                                     words_pending,
   output int                                     mismatches,
   output int                                     faded_words,
   output int                                     silenced_words
);

   localparam longint unsigned MS_PER_SECOND = 1000;
   localparam longint unsigned GAIN_UNITY    = 64'd1 << FRAC_W;

   // shadow copy of the csr registers
   logic [RATE_W-1:0]    cfg_rate;
   logic [MS_W-1:0]      cfg_ms;
   logic [CH_W-1:0]      cfg_ch;
   logic [SEG_LEN_W-1:0] cfg_len;

   // segment position and fade group counters
   logic [SEGMENT_BITS-1:0] seg_pos;
   int                      grp_phase;
   logic [GROUP_W-1:0]      grp_k;

   logic [SAMPLE_BITS-1:0] expected_samples[$];

   // faded value of one sample, advancing the segment counters
   function automatic logic [SAMPLE_BITS-1:0] fade_sample(
      input logic [SAMPLE_BITS-1:0] raw,
      input logic                   restart
   );
      logic signed [SAMPLE_BITS-1:0] raw_s;
      longint signed   level, faded;
      longint unsigned ch, frames, span, fade_start, l2, k, gain, mag, prod;
      raw_s = raw;
      level = raw_s;
      faded = level;
      ch = (cfg_ch == 0) ? 1 : (cfg_ch > MAX_CHANNELS) ? MAX_CHANNELS : cfg_ch;
      frames = cfg_rate;
      frames = frames * cfg_ms / MS_PER_SECOND;
      if (restart) begin
         seg_pos   = '0;
         grp_phase = 0;
         grp_k     = '0;
      end
      // fade length of zero frames leaves the word untouched
      if (frames != 0) begin
         span = frames * ch;
         fade_start = (cfg_len <= span) ? 0 : cfg_len - span - 1;
         if (seg_pos >= fade_start) begin
            k = grp_k;
            gain = 0;
            if (k < frames) begin
               l2 = frames * frames;
               gain = ((l2 - k * k) << FRAC_W) / l2;
            end
            mag = (level < 0) ? -level : level;
            prod = (mag * gain) >> FRAC_W;
            faded = (level < 0) ? -longint'(prod) : longint'(prod);
            if (gain == 0) silenced_words++;
            else if (gain < GAIN_UNITY) faded_words++;
            grp_phase++;
            if (grp_phase >= ch) begin
               grp_phase = 0;
               if (grp_k != '1) grp_k++;
            end
         end
      end
      if (seg_pos != '1) seg_pos++;
      return faded[SAMPLE_BITS-1:0];
   endfunction

   // compare results first, then predict the word taken at this edge
   always @(posedge clock) begin
      logic [SAMPLE_BITS-1:0] want;
      logic [SAMPLE_BITS-1:0] next_word;
      if (reset) begin
         cfg_rate  = RATE_RESET;
         cfg_ms    = MS_RESET;
         cfg_ch    = CH_RESET;
         cfg_len   = SEG_RESET;
         seg_pos   = '0;
         grp_phase = 0;
         grp_k     = '0;
         expected_samples.delete();
         mismatches     = 0;
         faded_words    = 0;
         silenced_words = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               $error("sample_out: word %0d arrived with nothing expected",
                      $signed(rsp_tdata[SAMPLE_BITS-1:0]));
               mismatches++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_tdata[SAMPLE_BITS-1:0] !== want) begin
                  $error("sample_out mismatch: expected %0d, actual %0d",
                         $signed(want), $signed(rsp_tdata[SAMPLE_BITS-1:0]));
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            next_word = fade_sample(req_tdata[SAMPLE_BITS-1:0], req_tuser);
            expected_samples = {expected_samples, next_word};
         end
         // csr writes land after the edge, so they follow the prediction
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SAMPLE_RATE:    cfg_rate = csr_wdata[RATE_W-1:0];
               CSR_FADE_MS:        cfg_ms   = csr_wdata[MS_W-1:0];
               CSR_CHANNEL_COUNT:  cfg_ch   = csr_wdata[CH_W-1:0];
               CSR_SEGMENT_LENGTH: cfg_len  = csr_wdata[SEG_LEN_W-1:0];
               default: ;
            endcase
         end
      end
      words_pending = expected_samples.size();
   end

endmodule

### tb/tb_quadratic_fadeout_gain.sv
`timescale 1ns / 100ps
// tb_quadratic_fadeout_gain: stimulus and verdict for the fade-out gain block
// drives csr, req and rsp channels; qfg_checker does prediction and comparison
// depends on qfg_pkg, quadratic_fadeout_gain and qfg_checker
module tb_quadratic_fadeout_gain;
   import qfg_pkg::*;

   localparam int SMP_W        = 24;
   localparam int RANDOM_WORDS = 600;
   localparam int IDLE_GAP     = 40;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SEG_MAX      = 24'hFFFFFF;
   localparam int RATE_MAX     = 192000;
   localparam int MS_MAX       = 10000;
   localparam int CH_OVER      = 15;

   // short one-channel segment: untouched head, full fade, silenced tail
   localparam logic [SMP_W-1:0] EDGE_WORDS[8] = '{
      24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
      24'hFFFFFF, 24'h000001, 24'h7FFFFF, 24'h00007B
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [SMP_W-1:0] req_tdata = '0;   // sample_in
   logic             req_tuser = 1'b0; // segment_start
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [SMP_W-1:0] rsp_tdata;        // sample_out
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int words_pending, mismatches, faded_words, silenced_words;
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   bit hold_rsp = 1'b0;
   int cycles = 0;
   int words_sent = 0;
   int settings_written = 0;

   quadratic_fadeout_gain dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_wr_en, .csr_index, .csr_wdata
   );

   qfg_checker scoreboard (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_wr_en, .csr_index, .csr_wdata,
      .words_pending, .mismatches, .faded_words, .silenced_words
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold to back up the block
   initial begin
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_tready <= (rx_stall_pct == 0) || ($urandom_range(0, 99) >= rx_stall_pct);
      end
   end

   // one word on req, entered and left at a falling edge
   task automatic send_word(input logic [SMP_W-1:0] smp, input logic restart);
      while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= smp;
      req_tuser  <= restart;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   // wait until every expected word is back and the block has gone quiet
   task automatic drain();
      req_tvalid <= 1'b0;
      while (words_pending != 0) @(negedge clock);
      repeat (IDLE_GAP) @(negedge clock);
   endtask

   // write all four registers, one per cycle
   task automatic program_regs(input int rate, input int ms, input int ch, input int len);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SAMPLE_RATE;
      csr_wdata <= CSR_DATA_W'(rate);
      @(negedge clock);
      csr_index <= CSR_FADE_MS;
      csr_wdata <= CSR_DATA_W'(ms);
      @(negedge clock);
      csr_index <= CSR_CHANNEL_COUNT;
      csr_wdata <= CSR_DATA_W'(ch);
      @(negedge clock);
      csr_index <= CSR_SEGMENT_LENGTH;
      csr_wdata <= CSR_DATA_W'(len);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      settings_written++;
   endtask

   // mostly random samples, sometimes full scale or near zero
   function automatic logic [SMP_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 24'h7FFFFF;
         1:       return 24'h800000;
         2:       return 24'h000000;
         3:       return 24'hFFFFFF;
         default: return SMP_W'($urandom);
      endcase
   endfunction

   initial begin
      int rate, ms, ch, chn, len, lt, seg_items, cut_at, restart_at, new_len, words_random;
      longint unsigned frames, span;
      bit pressure_done;
      words_random  = 0;
      pressure_done = 1'b0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fade disabled out of reset: full scale and zero pass as they are
      send_word(24'h7FFFFF, 1'b1);
      send_word(24'h800000, 1'b0);
      send_word(24'h000000, 1'b0);
      drain();

      program_regs(1000, 4, 1, 6);
      foreach (EDGE_WORDS[i]) send_word(EDGE_WORDS[i], i == 0);
      drain();

      // channel count of zero acts as one, empty segment fades from the start
      program_regs(2000, 1, 0, 0);
      send_word(24'h7FFFFF, 1'b1);
      send_word(24'h800000, 1'b0);
      send_word(24'h400001, 1'b0);
      drain();

      // large register values, channel count above the maximum
      program_regs(RATE_MAX, MS_MAX, CH_OVER, SEG_MAX);
      send_word(24'h800000, 1'b1);
      send_word(24'h7FFFFF, 1'b0);
      send_word(24'h123456, 1'b0);
      send_word(24'hFFFFFF, 1'b0);
      drain();

      // segment length shortened mid-segment, then a restart
      program_regs(1000, 3, 2, 20);
      send_word(24'h7FFFFF, 1'b1);
      send_word(24'h800000, 1'b0);
      drain();
      program_regs(1000, 3, 2, 8);
      send_word(24'h7FFFFF, 1'b0);
      send_word(24'h800000, 1'b0);
      send_word(24'h654321, 1'b0);
      send_word(24'h800000, 1'b1);
      drain();

      // nonzero fade time that still rounds down to zero frames
      program_regs(1, 999, 8, 0);
      send_word(24'h800000, 1'b1);

      // random segments, idling mode changing every quarter
      while (words_random < RANDOM_WORDS) begin
         case (words_random * 4 / RANDOM_WORDS)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 60; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 60; end
            default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
         endcase
         drain();
         if (!pressure_done) begin
            hold_rsp = 1'b1;
            pressure_done = 1'b1;
         end

         ch = ($urandom_range(0, 9) == 0) ? $urandom_range(0, CH_OVER) : $urandom_range(1, 8);
         chn = (ch == 0) ? 1 : (ch > 8) ? 8 : ch;
         rate = ($urandom_range(0, 9) < 7) ? $urandom_range(100, 12000)
                                           : $urandom_range(1, RATE_MAX);
         if ($urandom_range(0, 9) == 0) begin
            ms = 0;
         end else begin
            lt = $urandom_range(1, 8);
            ms = lt * 1000 / rate;
            if (ms < 1) ms = 1;
            if (ms > MS_MAX) ms = MS_MAX;
         end
         frames = rate;
         frames = frames * ms / 1000;
         span = frames * chn;
         // short-span segments reach the fade; others mostly stay far before it
         if (frames != 0 && span <= 100 && $urandom_range(0, 9) != 0) begin
            len = $urandom_range(0, int'(span) + 2 * chn + 10);
            seg_items = len + $urandom_range(1, 2 * chn + 4);
            if (seg_items > 150) seg_items = 150;
         end else begin
            len = $urandom_range(0, SEG_MAX);
            seg_items = $urandom_range(3, 16);
         end
         cut_at = ($urandom_range(0, 99) < 15) ? $urandom_range(1, seg_items - 1) : -1;
         restart_at = ($urandom_range(0, 99) < 10) ? $urandom_range(1, seg_items - 1) : -1;
         new_len = $urandom_range(0, int'(span) + 2 * chn + 10);

         program_regs(rate, ms, ch, len);
         for (int i = 0; i < seg_items; i++) begin
            if (i == cut_at) begin
               drain();
               program_regs(rate, ms, ch, new_len);
            end
            send_word(pick_sample(), i == 0 || i == restart_at);
            words_random++;
         end
      end

      drain();
      $display("covered %0d words over %0d register settings: %0d faded, %0d silenced",
               words_sent, settings_written, faded_words, silenced_words);
      $display("idling: none, sender, receiver, both; one %0d-cycle receiver hold",
               HOLD_CYCLES);
      if (mismatches == 0 && words_pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
